// ===== hdl/nla_pkg.sv =====
// ----------------------------------------------------------------------------
// nla_pkg
// Shared widths, fixed-point constants and the sequencer program for the
// natural log approximator.
// ----------------------------------------------------------------------------
`default_nettype none

package nla_pkg;

	// Number formats
	localparam int INPUT_FRAC_BITS  = 8;
	localparam int OUTPUT_FRAC_BITS = 16;
	localparam int QF               = 30;     // mantissa / coefficient fraction bits
	localparam int OUT_SHIFT        = QF - OUTPUT_FRAC_BITS;

	localparam int VAL_W  = 32;
	localparam int LOG_W  = 22;
	localparam int P_W    = 5;                // leading-one position 0..31
	localparam int EXP_W  = 7;                // signed p - INPUT_FRAC_BITS
	localparam int ACC_W  = 34;               // Horner accumulator, signed Q30
	localparam int MB_W   = 32;               // multiplier B operand, signed
	localparam int PROD_W = ACC_W + MB_W;
	localparam int TOT_W  = 40;               // acc + exponent term, signed Q30

	// Horner coefficients, signed Q30
	localparam logic signed [ACC_W-1:0] C0 = -34'sd1870236959;
	localparam logic signed [ACC_W-1:0] C1 =  34'sd3029243226;
	localparam logic signed [ACC_W-1:0] C2 = -34'sd1578354096;
	localparam logic signed [ACC_W-1:0] C3 =  34'sd480155386;
	localparam logic signed [ACC_W-1:0] C4 = -34'sd60742489;
	localparam logic signed [MB_W-1:0]  LN2_Q30 = 32'sd744261117;

	localparam logic signed [PROD_W-1:0] HALF_Q =
		PROD_W'(64'd1 << (QF - 1));
	localparam logic signed [TOT_W-1:0] HALF_OUT =
		TOT_W'(64'd1 << (OUT_SHIFT - 1));
	localparam logic signed [TOT_W-1:0] NEG_ONE =
		-TOT_W'(64'd1 << OUTPUT_FRAC_BITS);
	localparam logic signed [TOT_W-1:0] LOG_MAX = TOT_W'((64'd1 << (LOG_W - 1)) - 64'd1);
	localparam logic signed [TOT_W-1:0] LOG_MIN = -TOT_W'(64'd1 << (LOG_W - 1));

	// Micro-operations
	localparam logic [2:0] OP_NORM  = 3'd0;   // normalise step, arg = shift
	localparam logic [2:0] OP_MUL   = 3'd1;   // prod = acc * m
	localparam logic [2:0] OP_ADD   = 3'd2;   // acc = round(prod) + coef[arg]
	localparam logic [2:0] OP_LNMUL = 3'd3;   // prod = (p - frac) * ln2
	localparam logic [2:0] OP_FIN   = 3'd4;   // round, saturate, write result

	// Coefficient selects
	localparam logic [4:0] SEL_C0 = 5'd0;
	localparam logic [4:0] SEL_C1 = 5'd1;
	localparam logic [4:0] SEL_C2 = 5'd2;
	localparam logic [4:0] SEL_C3 = 5'd3;

	localparam int STEP_W = 4;
	localparam logic [STEP_W-1:0] STEP_FIN = 4'd14;

	typedef struct packed {
		logic [2:0]        op;
		logic [4:0]        arg;
		logic              jz;     // jump to tgt when the input was zero
		logic [STEP_W-1:0] tgt;
	} ctrl_word_t;

	function automatic ctrl_word_t prog_word(input logic [STEP_W-1:0] step);
		ctrl_word_t cw;
		cw = '{op: OP_FIN, arg: 5'd0, jz: 1'b0, tgt: '0};
		case (step)
			4'd0:  cw = '{op: OP_NORM,  arg: 5'd16,  jz: 1'b1, tgt: STEP_FIN};
			4'd1:  cw = '{op: OP_NORM,  arg: 5'd8,   jz: 1'b0, tgt: '0};
			4'd2:  cw = '{op: OP_NORM,  arg: 5'd4,   jz: 1'b0, tgt: '0};
			4'd3:  cw = '{op: OP_NORM,  arg: 5'd2,   jz: 1'b0, tgt: '0};
			4'd4:  cw = '{op: OP_NORM,  arg: 5'd1,   jz: 1'b0, tgt: '0};
			4'd5:  cw = '{op: OP_MUL,   arg: 5'd0,   jz: 1'b0, tgt: '0};
			4'd6:  cw = '{op: OP_ADD,   arg: SEL_C3, jz: 1'b0, tgt: '0};
			4'd7:  cw = '{op: OP_MUL,   arg: 5'd0,   jz: 1'b0, tgt: '0};
			4'd8:  cw = '{op: OP_ADD,   arg: SEL_C2, jz: 1'b0, tgt: '0};
			4'd9:  cw = '{op: OP_MUL,   arg: 5'd0,   jz: 1'b0, tgt: '0};
			4'd10: cw = '{op: OP_ADD,   arg: SEL_C1, jz: 1'b0, tgt: '0};
			4'd11: cw = '{op: OP_MUL,   arg: 5'd0,   jz: 1'b0, tgt: '0};
			4'd12: cw = '{op: OP_ADD,   arg: SEL_C0, jz: 1'b0, tgt: '0};
			4'd13: cw = '{op: OP_LNMUL, arg: 5'd0,   jz: 1'b0, tgt: '0};
			default: cw = '{op: OP_FIN, arg: 5'd0,   jz: 1'b0, tgt: '0};
		endcase
		return cw;
	endfunction

	function automatic logic signed [ACC_W-1:0] coef_sel(input logic [4:0] sel);
		logic signed [ACC_W-1:0] c;
		case (sel)
			SEL_C0:  c = C0;
			SEL_C1:  c = C1;
			SEL_C2:  c = C2;
			SEL_C3:  c = C3;
			default: c = C0;
		endcase
		return c;
	endfunction

endpackage

`default_nettype wire

// ===== hdl/natural_log_approximator.sv =====
// ----------------------------------------------------------------------------
// natural_log_approximator
// Natural log of an unsigned Q24.8 value by a degree-4 polynomial, run as a
// short microprogram over one shared multiplier.
// ----------------------------------------------------------------------------
// Usage:
//   Input beat on in_valid/in_stall carries value_q24_8. Output beat on
//   out_valid/out_stall carries log_q16 (signed Q6.16) and invalid_input.
//   One item is in flight at a time; in_stall is high while it is worked on.
//   A non-zero input walks 15 microprogram steps: five normalise steps
//   (binary leading-one search), four multiply/add pairs of Horner's rule on
//   the shared 34x32 multiplier, the exponent product and a final round.
//   The result is written to the output register on the final step, and a new
//   beat is taken once the sequencer has left that step. A zero input jumps
//   from the first step straight to the final step.
//   The result sits in an output register, so the next beat is taken while
//   it waits. If it is still waiting when the next result is ready, the
//   sequencer holds on its final step until out_stall drops.
//   Reset (arst_n low) empties the block; no result is pending afterwards.
// ----------------------------------------------------------------------------
`default_nettype none

module natural_log_approximator
	import nla_pkg::*;
(
	input  wire logic                     clk,
	input  wire logic                     arst_n,
	input  wire logic                     in_valid,
	output logic                          in_stall,
	input  wire logic [VAL_W-1:0]         value_q24_8,
	output logic                          out_valid,
	input  wire logic                     out_stall,
	output logic signed [LOG_W-1:0]       log_q16,
	output logic                          invalid_input
);

	logic                      busy_q;
	logic [STEP_W-1:0]         step_q;
	logic                      out_valid_q;
	logic [VAL_W-1:0]          x_q;
	logic [P_W-1:0]            p_q;
	logic                      zero_q;
	logic signed [ACC_W-1:0]   acc_q;
	logic signed [PROD_W-1:0]  prod_q;
	logic signed [LOG_W-1:0]   log_q;
	logic                      inv_q;

	ctrl_word_t                cw;
	logic                      in_acc;
	logic                      fin_go;
	logic [STEP_W-1:0]         step_nxt;
	logic [5:0]                sh;
	logic                      top_zero;
	logic signed [EXP_W-1:0]   ln_exp;
	logic signed [ACC_W-1:0]   mul_a;
	logic signed [MB_W-1:0]    mul_b;
	logic signed [PROD_W-1:0]  mul_p;
	logic signed [PROD_W-1:0]  prod_rnd;
	logic signed [TOT_W-1:0]   total;
	logic signed [TOT_W-1:0]   fin_rnd;
	logic signed [TOT_W-1:0]   fin_val;
	logic signed [LOG_W-1:0]   fin_sat;

	assign cw        = prog_word(step_q);
	assign in_stall  = busy_q;
	assign in_acc    = in_valid && !in_stall;
	assign out_valid = out_valid_q;
	assign log_q16   = log_q;
	assign invalid_input = inv_q;

	// final step waits for the output register to be free
	assign fin_go   = (cw.op == OP_FIN) && (!out_valid_q || !out_stall);
	assign step_nxt = (cw.jz && zero_q) ? cw.tgt : step_q + 1'b1;

	// normalise: shift left by sh when the top sh bits are all clear
	assign sh       = {1'b0, cw.arg};
	assign top_zero = (x_q >> (6'd32 - sh)) == '0;

	assign ln_exp = signed'({2'b00, p_q}) - EXP_W'(INPUT_FRAC_BITS);

	always_comb begin
		if (cw.op == OP_LNMUL) begin
			mul_a = ACC_W'(ln_exp);
			mul_b = LN2_Q30;
		end else begin
			mul_a = acc_q;
			mul_b = signed'({1'b0, x_q[VAL_W-1:1]});  // mantissa, Q30
		end
	end

	assign mul_p    = mul_a * mul_b;
	assign prod_rnd = (prod_q + HALF_Q) >>> QF;

	assign total   = TOT_W'(acc_q) + signed'(prod_q[TOT_W-1:0]);
	assign fin_rnd = (total + HALF_OUT) >>> OUT_SHIFT;
	assign fin_val = zero_q ? NEG_ONE : fin_rnd;

	always_comb begin
		if (fin_val > LOG_MAX) begin
			fin_sat = LOG_MAX[LOG_W-1:0];
		end else if (fin_val < LOG_MIN) begin
			fin_sat = LOG_MIN[LOG_W-1:0];
		end else begin
			fin_sat = fin_val[LOG_W-1:0];
		end
	end

	// sequencer and handshake control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q      <= 1'b0;
			step_q      <= '0;
			out_valid_q <= 1'b0;
		end else begin
			// a new result may replace the one leaving in the same cycle
			if (busy_q && fin_go) begin
				out_valid_q <= 1'b1;
			end else if (out_valid_q && !out_stall) begin
				out_valid_q <= 1'b0;
			end
			if (in_acc) begin
				busy_q <= 1'b1;
				step_q <= '0;
			end else if (busy_q) begin
				if (cw.op == OP_FIN) begin
					if (fin_go) begin
						busy_q <= 1'b0;
					end
				end else begin
					step_q <= step_nxt;
				end
			end
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		if (in_acc) begin
			x_q    <= value_q24_8;
			p_q    <= P_W'(VAL_W - 1);
			zero_q <= (value_q24_8 == '0);
			acc_q  <= C4;
		end else if (busy_q) begin
			case (cw.op)
				OP_NORM: begin
					if (top_zero) begin
						x_q <= x_q << sh;
						p_q <= p_q - sh[P_W-1:0];
					end
				end
				OP_MUL, OP_LNMUL: begin
					prod_q <= mul_p;
				end
				OP_ADD: begin
					acc_q <= signed'(prod_rnd[ACC_W-1:0]) + coef_sel(cw.arg);
				end
				OP_FIN: begin
					if (fin_go) begin
						log_q <= fin_sat;
						inv_q <= zero_q;
					end
				end
				default: begin
				end
			endcase
		end
	end

`ifndef SYNTH
	a_accept_starts: assert property (@(posedge clk) disable iff (!arst_n)
		in_acc |=> (busy_q && step_q == '0))
		else $error("accepted beat did not start the program");

	a_step_range: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> (step_q <= STEP_FIN))
		else $error("step counter ran past the final step");

	a_fin_delivers: assert property (@(posedge clk) disable iff (!arst_n)
		(busy_q && fin_go) |=> (out_valid_q && !busy_q))
		else $error("final step did not present a result");

	a_zero_result: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && inv_q) |-> (log_q == NEG_ONE[LOG_W-1:0]))
		else $error("zero input gave a value other than -1.0");

	a_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && out_stall) |=> (out_valid_q && $stable(log_q)))
		else $error("pending result overwritten while stalled");
`endif

endmodule

`default_nettype wire
